// ===== rtl/page_anchor_key_cache_core_defines.svh =====
// Assertion helpers shared by the RTL.
`ifndef PAGE_ANCHOR_KEY_CACHE_CORE_DEFINES_SVH
`define PAGE_ANCHOR_KEY_CACHE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PAKC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("page anchor key cache: check failed");

// Next-cycle implication, disabled during reset.
`define PAKC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("page anchor key cache: check failed");

`endif

// ===== rtl/pakc_pkg.sv =====
package pakc_pkg;

   localparam int ENTRIES_DEF = 16;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_RECORD = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [63:0] store_ids;
      logic [63:0] relation_block;
      logic [1:0]  fork_num;
      logic [63:0] incarnation_high;
      logic [63:0] incarnation_low;
      logic [63:0] lineage_high;
      logic [63:0] lineage_low;
      logic [63:0] ckpt_epoch;
      logic [63:0] image_epoch;
   } key_type;

   localparam int KEY_W = $bits(key_type);

endpackage

// ===== rtl/page_anchor_key_cache_core.sv =====
// Page anchor key cache: a fully associative set of ENTRIES page-anchor keys.
// Input channel req_*: one item per operation (lookup, record, clear all),
// taken when req_valid is high and req_stall is low. Result channel rsp_*:
// exactly one item per request, rsp_force_image for lookups and rsp_record_ok
// for records; the field that does not apply reads 0.
// Lookups with a valid key, and records with a valid key and events done,
// walk the key memory one slot per cycle through a single comparator,
// stopping early on a hit. Clear, unused codes and refused items skip the
// walk and go straight to the result.
// A new item is accepted in the cycle after the previous one has reached the
// output register, even while that result is still stalled.
// When the receiver holds rsp_stall, the result stays in the output register
// and a following result waits in the block, which then stalls req_*.
// Reset (synchronous, active high) drops every valid bit and all control
// state; stored key contents are kept but can no longer match.
module page_anchor_key_cache_core #(
   parameter int ENTRIES = pakc_pkg::ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [63:0] req_store_ids,
   input  logic [63:0] req_relation_block,
   input  logic [1:0]  req_fork_req,
   input  logic [63:0] req_incarnation_high,
   input  logic [63:0] req_incarnation_low,
   input  logic [63:0] req_lineage_high,
   input  logic [63:0] req_lineage_low,
   input  logic [63:0] req_ckpt_epoch,
   input  logic [63:0] req_image_epoch,
   input  logic        req_identity_ok,
   input  logic        req_events_done,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_force_image,
   output logic        rsp_record_ok
);

   `include "page_anchor_key_cache_core_defines.svh"

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   pakc_pkg::state_type state_ff, state_in;
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic                is_record_ff, is_record_in;
   logic [IDX_W-1:0]    issue_idx_ff, issue_idx_in;
   logic                issue_on_ff, issue_on_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]    empty_idx_ff, empty_idx_in;
   logic                res_force_ff, res_force_in;
   logic                res_ok_ff, res_ok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_force_image_ff, rsp_force_image_in;
   logic                rsp_record_ok_ff, rsp_record_ok_in;
   pakc_pkg::key_type   key_ff, key_in;

   pakc_pkg::key_type   req_key;
   pakc_pkg::key_type   rd_key;
   logic                key_ok;
   logic                slot_match;
   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic                ram_rd_en;

   assign req_key.store_ids        = req_store_ids;
   assign req_key.relation_block   = req_relation_block;
   assign req_key.fork_num         = req_fork_req;
   assign req_key.incarnation_high = req_incarnation_high;
   assign req_key.incarnation_low  = req_incarnation_low;
   assign req_key.lineage_high     = req_lineage_high;
   assign req_key.lineage_low      = req_lineage_low;
   assign req_key.ckpt_epoch       = req_ckpt_epoch;
   assign req_key.image_epoch      = req_image_epoch;

   assign key_ok = req_identity_ok
                && ((req_incarnation_high | req_incarnation_low) != 64'd0)
                && ((req_lineage_high | req_lineage_low) != 64'd0)
                && (req_ckpt_epoch != 64'd0)
                && (req_image_epoch != 64'd0);

   pakc_key_ram #(
      .ENTRIES (ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (key_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_idx_ff),
      .rd_data (rd_key)
   );

   pakc_key_cmp u_key_cmp (
      .entry_key (rd_key),
      .probe_key (key_ff),
      .equal     (slot_match)
   );

   assign req_stall = (state_ff != pakc_pkg::ST_IDLE);

   always_comb begin
      logic [IDX_W-1:0] target;

      state_in           = state_ff;
      valid_in           = valid_ff;
      is_record_in       = is_record_ff;
      issue_idx_in       = issue_idx_ff;
      issue_on_in        = issue_on_ff;
      cmp_vld_in         = cmp_vld_ff;
      cmp_idx_in         = cmp_idx_ff;
      empty_found_in     = empty_found_ff;
      empty_idx_in       = empty_idx_ff;
      res_force_in       = res_force_ff;
      res_ok_in          = res_ok_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_force_image_in = rsp_force_image_ff;
      rsp_record_ok_in   = rsp_record_ok_ff;
      key_in             = key_ff;
      ram_wr_en          = 1'b0;
      ram_rd_en          = 1'b0;
      target             = empty_found_ff ? empty_idx_ff : cmp_idx_ff;
      ram_wr_addr        = target;

      // drain the output register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         pakc_pkg::ST_IDLE: begin
            if (req_valid) begin
               key_in         = req_key;
               issue_idx_in   = '0;
               empty_found_in = 1'b0;
               cmp_vld_in     = 1'b0;
               res_force_in   = 1'b0;
               res_ok_in      = 1'b0;
               state_in       = pakc_pkg::ST_RESP;
               unique case (pakc_pkg::op_type'(req_operation))
                  pakc_pkg::OP_LOOKUP: begin
                     if (key_ok) begin
                        is_record_in = 1'b0;
                        issue_on_in  = 1'b1;
                        state_in     = pakc_pkg::ST_SCAN;
                     end else begin
                        res_force_in = 1'b1;
                     end
                  end
                  pakc_pkg::OP_RECORD: begin
                     if (key_ok && req_events_done) begin
                        is_record_in = 1'b1;
                        issue_on_in  = 1'b1;
                        state_in     = pakc_pkg::ST_SCAN;
                     end
                  end
                  pakc_pkg::OP_CLEAR: begin
                     valid_in = '0;
                  end
                  default: begin
                     // unused code: answer with both fields low
                  end
               endcase
            end
         end

         pakc_pkg::ST_SCAN: begin
            // issue one memory read per cycle
            cmp_vld_in = issue_on_ff;
            cmp_idx_in = issue_idx_ff;
            if (issue_on_ff) begin
               ram_rd_en = 1'b1;
               if (issue_idx_ff == LAST_IDX) begin
                  issue_on_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + 1'b1;
               end
            end

            // compare the slot read last cycle
            if (cmp_vld_ff) begin
               if (!valid_ff[cmp_idx_ff] && !empty_found_ff) begin
                  empty_found_in = 1'b1;
                  empty_idx_in   = cmp_idx_ff;
               end
               if (valid_ff[cmp_idx_ff] && slot_match) begin
                  res_force_in = 1'b0;
                  res_ok_in    = is_record_ff;
                  issue_on_in  = 1'b0;
                  cmp_vld_in   = 1'b0;
                  state_in     = pakc_pkg::ST_RESP;
               end else if (cmp_idx_ff == LAST_IDX) begin
                  res_force_in = !is_record_ff;
                  res_ok_in    = 1'b0;
                  cmp_vld_in   = 1'b0;
                  state_in     = pakc_pkg::ST_RESP;
                  if (is_record_ff && (empty_found_ff || !valid_ff[cmp_idx_ff])) begin
                     ram_wr_en        = 1'b1;
                     valid_in[target] = 1'b1;
                     res_ok_in        = 1'b1;
                  end
               end
            end
         end

         pakc_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_force_image_in = res_force_ff;
               rsp_record_ok_in   = res_ok_ff;
               state_in           = pakc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pakc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pakc_pkg::ST_IDLE;
         valid_ff     <= '0;
         issue_on_ff  <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         issue_on_ff  <= issue_on_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_record_ff       <= is_record_in;
      issue_idx_ff       <= issue_idx_in;
      cmp_idx_ff         <= cmp_idx_in;
      empty_found_ff     <= empty_found_in;
      empty_idx_ff       <= empty_idx_in;
      res_force_ff       <= res_force_in;
      res_ok_ff          <= res_ok_in;
      rsp_force_image_ff <= rsp_force_image_in;
      rsp_record_ok_ff   <= rsp_record_ok_in;
      key_ff             <= key_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_force_image = rsp_force_image_ff;
   assign rsp_record_ok   = rsp_record_ok_ff;

   `PAKC_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall)
   `PAKC_ASSERT_NEXT(a_clear_empties, clock, reset,
      req_valid && !req_stall && (req_operation == pakc_pkg::OP_CLEAR), valid_ff == '0)
   `PAKC_ASSERT_NEXT(a_valid_grows, clock, reset,
      !(req_valid && !req_stall && (req_operation == pakc_pkg::OP_CLEAR)),
      $countones(valid_ff) >= $countones($past(valid_ff)))
   `PAKC_ASSERT_NOW(a_one_field, clock, reset, rsp_valid, !(rsp_force_image && rsp_record_ok))

endmodule

// ===== rtl/pakc_key_ram.sv =====
module pakc_key_ram #(
   parameter int ENTRIES = pakc_pkg::ENTRIES_DEF
) (
   input  logic                                             clock,
   input  logic                                             wr_en,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
   input  pakc_pkg::key_type                                wr_data,
   input  logic                                             rd_en,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
   output pakc_pkg::key_type                                rd_data
);

   pakc_pkg::key_type mem_ff [ENTRIES];
   pakc_pkg::key_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pakc_key_cmp.sv =====
module pakc_key_cmp (
   input  pakc_pkg::key_type entry_key,
   input  pakc_pkg::key_type probe_key,
   output logic              equal
);

   // Field-wise equality over the whole key; the packed form makes it one wide compare.
   assign equal = (entry_key == probe_key);

endmodule

// ===== bench/page_anchor_key_cache_core_test.sv =====
module page_anchor_key_cache_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS = pakc_pkg::ENTRIES_DEF;
   localparam int KEY_POOL = 24;
   localparam int RANDOM_ITEMS = 1900;
   localparam int DRAIN_CYCLES = 2 * (TABLE_SLOTS + 3);
   localparam int IDLE_LIMIT = 2000;
   localparam int REPORT_LIMIT = 10;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]        op;
      pakc_pkg::key_type key;
      logic              identity_ok;
      logic              events_done;
   } anchor_req_type;

   typedef struct packed {
      logic force_image;
      logic record_ok;
   } anchor_reply_type;

   typedef struct {
      anchor_req_type   req;
      bit               typed;
      anchor_reply_type reply;
   } plan_row_type;

   typedef enum {
      BREAK_IDENTITY,
      BREAK_INCARNATION,
      BREAK_LINEAGE,
      BREAK_CHECKPOINT,
      BREAK_IMAGE
   } key_flaw_type;

   typedef enum logic [1:0] {
      FLOW_OPEN,
      FLOW_RANDOM,
      FLOW_PATTERN,
      FLOW_HOLDS
   } sink_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [63:0] req_store_ids = '0;
   logic [63:0] req_relation_block = '0;
   logic [1:0]  req_fork_req = '0;
   logic [63:0] req_incarnation_high = '0;
   logic [63:0] req_incarnation_low = '0;
   logic [63:0] req_lineage_high = '0;
   logic [63:0] req_lineage_low = '0;
   logic [63:0] req_ckpt_epoch = '0;
   logic [63:0] req_image_epoch = '0;
   logic        req_identity_ok = 1'b0;
   logic        req_events_done = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_force_image;
   logic        rsp_record_ok;

   // Predictor copy of the key table
   pakc_pkg::key_type cached_key [TABLE_SLOTS];
   logic              cached_valid [TABLE_SLOTS];
   anchor_reply_type  pending_replies [$];
   pakc_pkg::key_type key_pool [KEY_POOL];
   plan_row_type      plan [$];

   int            fault_count = 0;
   int            idle_cycles = 0;
   int            burst_left = 0;
   bit            steady = 1'b0;
   sink_mode_type stall_mode = FLOW_OPEN;
   int            stall_left = 0;
   logic [11:0]   stall_pattern = 12'b1011_0001_1100;

   page_anchor_key_cache_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_store_ids(req_store_ids),
      .req_relation_block(req_relation_block),
      .req_fork_req(req_fork_req),
      .req_incarnation_high(req_incarnation_high),
      .req_incarnation_low(req_incarnation_low),
      .req_lineage_high(req_lineage_high),
      .req_lineage_low(req_lineage_low),
      .req_ckpt_epoch(req_ckpt_epoch),
      .req_image_epoch(req_image_epoch),
      .req_identity_ok(req_identity_ok),
      .req_events_done(req_events_done),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_force_image(rsp_force_image),
      .rsp_record_ok(rsp_record_ok)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit key_usable(anchor_req_type r);
      return r.identity_ok && (r.key.incarnation_high | r.key.incarnation_low) != 0
         && (r.key.lineage_high | r.key.lineage_low) != 0
         && r.key.ckpt_epoch != 0 && r.key.image_epoch != 0;
   endfunction

   // Apply one item to the table copy and return the reply it must produce
   function automatic anchor_reply_type predict_anchor_reply(anchor_req_type r);
      anchor_reply_type rep;
      int free_slot;
      bit found;
      rep = '0;
      free_slot = -1;
      found = 1'b0;
      case (r.op)
         pakc_pkg::OP_LOOKUP: begin
            if (key_usable(r)) begin
               for (int s = 0; s < TABLE_SLOTS; s++) begin
                  if (cached_valid[s] && cached_key[s] == r.key) found = 1'b1;
               end
            end
            rep.force_image = !found;
         end
         pakc_pkg::OP_RECORD: begin
            if (r.events_done && key_usable(r)) begin
               for (int s = 0; s < TABLE_SLOTS; s++) begin
                  if (cached_valid[s]) begin
                     if (cached_key[s] == r.key) found = 1'b1;
                  end else if (free_slot < 0) begin
                     free_slot = s;
                  end
               end
               if (found) begin
                  rep.record_ok = 1'b1;
               end else if (free_slot >= 0) begin
                  cached_key[free_slot] = r.key;
                  cached_valid[free_slot] = 1'b1;
                  rep.record_ok = 1'b1;
               end
            end
         end
         pakc_pkg::OP_CLEAR: begin
            for (int s = 0; s < TABLE_SLOTS; s++) cached_valid[s] = 1'b0;
         end
         default: ;
      endcase
      return rep;
   endfunction

   function automatic pakc_pkg::key_type rand_key();
      pakc_pkg::key_type k;
      k.store_ids = {$urandom(), $urandom()};
      k.relation_block = {$urandom(), $urandom()};
      k.fork_num = 2'($urandom_range(0, 3));
      k.incarnation_high = {$urandom(), $urandom()};
      k.incarnation_low = {$urandom(), $urandom()};
      k.lineage_high = {$urandom(), $urandom()};
      k.lineage_low = {$urandom(), $urandom()};
      k.ckpt_epoch = {$urandom(), $urandom()};
      k.image_epoch = {$urandom(), $urandom()};
      return k;
   endfunction

   // Mostly well-formed keys from a small pool so the table hits and fills up
   function automatic anchor_req_type random_request();
      anchor_req_type r;
      int pick;
      int shape;
      logic [pakc_pkg::KEY_W-1:0] flip;
      pick = $urandom_range(0, 99);
      shape = $urandom_range(0, 99);
      if (pick < 1) r.op = pakc_pkg::OP_CLEAR;
      else if (pick < 3) r.op = OP_UNUSED;
      else if (pick < 50) r.op = pakc_pkg::OP_LOOKUP;
      else r.op = pakc_pkg::OP_RECORD;
      r.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      r.identity_ok = 1'b1;
      r.events_done = ($urandom_range(0, 19) != 0);
      if (shape < 10) begin
         // near miss: one bit off a pool key
         flip = '0;
         flip[$urandom_range(0, pakc_pkg::KEY_W - 1)] = 1'b1;
         r.key = r.key ^ flip;
      end else if (shape < 15) begin
         r.key = rand_key();
      end else if (shape < 22) begin
         case (key_flaw_type'($urandom_range(0, 4)))
            BREAK_IDENTITY: r.identity_ok = 1'b0;
            BREAK_INCARNATION: begin
               r.key.incarnation_high = '0;
               r.key.incarnation_low = '0;
            end
            BREAK_LINEAGE: begin
               r.key.lineage_high = '0;
               r.key.lineage_low = '0;
            end
            BREAK_CHECKPOINT: r.key.ckpt_epoch = '0;
            default: r.key.image_epoch = '0;
         endcase
      end
      if ($urandom_range(0, 32) == 0) key_pool[$urandom_range(0, KEY_POOL - 1)] = rand_key();
      return r;
   endfunction

   task automatic add_row(logic [1:0] op, pakc_pkg::key_type k, logic idok, logic evd,
                          bit typed, logic force_i, logic rec_ok);
      plan_row_type row;
      row.req = '{op: op, key: k, identity_ok: idok, events_done: evd};
      row.typed = typed;
      row.reply = '{force_image: force_i, record_ok: rec_ok};
      plan.push_back(row);
   endtask

   task automatic flag_fault(string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("%t: %s", $realtime, msg);
   endtask

   // Drive one item in bursts, hold it until taken, then record its expectation
   task automatic send_item(anchor_req_type r, bit typed, anchor_reply_type typed_reply);
      anchor_reply_type predicted;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if (!steady) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_operation <= r.op;
      req_store_ids <= r.key.store_ids;
      req_relation_block <= r.key.relation_block;
      req_fork_req <= r.key.fork_num;
      req_incarnation_high <= r.key.incarnation_high;
      req_incarnation_low <= r.key.incarnation_low;
      req_lineage_high <= r.key.lineage_high;
      req_lineage_low <= r.key.lineage_low;
      req_ckpt_epoch <= r.key.ckpt_epoch;
      req_image_epoch <= r.key.image_epoch;
      req_identity_ok <= r.identity_ok;
      req_events_done <= r.events_done;
      do @(posedge clock); while (req_stall);
      predicted = predict_anchor_reply(r);
      pending_replies.push_back(typed ? typed_reply : predicted);
   endtask

   // Receiver back-pressure: switch at random between flow styles
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= sink_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(50, 300);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_pattern <= {stall_pattern[10:0], stall_pattern[11]};
      case (stall_mode)
         FLOW_OPEN: rsp_stall <= 1'b0;
         FLOW_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
         FLOW_PATTERN: rsp_stall <= stall_pattern[11];
         default: rsp_stall <= ($urandom_range(0, 15) == 0) ? !rsp_stall : rsp_stall;
      endcase
   end

   always @(posedge clock) begin
      anchor_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            flag_fault($sformatf("reply with nothing pending: force_image=%0b record_ok=%0b",
                                 rsp_force_image, rsp_record_ok));
         end else begin
            want = pending_replies.pop_front();
            if (rsp_force_image !== want.force_image)
               flag_fault($sformatf("force_image expected %0b got %0b",
                                    want.force_image, rsp_force_image));
            if (rsp_record_ok !== want.record_ok)
               flag_fault($sformatf("record_ok expected %0b got %0b",
                                    want.record_ok, rsp_record_ok));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("page_anchor_key_cache_core test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      pakc_pkg::key_type k1;
      pakc_pkg::key_type k2;
      pakc_pkg::key_type kmax;
      pakc_pkg::key_type kmin;
      pakc_pkg::key_type kx;
      for (int s = 0; s < TABLE_SLOTS; s++) begin
         cached_valid[s] = 1'b0;
         cached_key[s] = '0;
      end
      foreach (key_pool[i]) key_pool[i] = rand_key();

      k1 = '{store_ids: 64'h0000_0611_0000_0005, relation_block: 64'h0000_4000_0000_0010,
             fork_num: 2'd1, incarnation_high: 64'h0, incarnation_low: 64'h77,
             lineage_high: 64'h1234, lineage_low: 64'h0,
             ckpt_epoch: 64'd3, image_epoch: 64'd9};
      k2 = k1;
      k2.relation_block = 64'h0000_4000_0000_0011;
      kmax = '1;
      kmin = '0;
      kmin.incarnation_high = 64'd1;
      kmin.lineage_low = 64'd1;
      kmin.ckpt_epoch = 64'd1;
      kmin.image_epoch = 64'd1;

      add_row(pakc_pkg::OP_LOOKUP, k1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);   // empty table misses
      add_row(pakc_pkg::OP_RECORD, k1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);   // first insert
      add_row(pakc_pkg::OP_LOOKUP, k1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(pakc_pkg::OP_RECORD, k1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      // refused records: events not done, then each way of making the key invalid
      add_row(pakc_pkg::OP_RECORD, k2, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
      add_row(pakc_pkg::OP_RECORD, k2, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
      kx = k2;
      kx.incarnation_low = '0;
      add_row(pakc_pkg::OP_RECORD, kx, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      kx = k2;
      kx.lineage_high = '0;
      add_row(pakc_pkg::OP_RECORD, kx, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      kx = k2;
      kx.ckpt_epoch = '0;
      add_row(pakc_pkg::OP_RECORD, kx, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      kx = k2;
      kx.image_epoch = '0;
      add_row(pakc_pkg::OP_RECORD, kx, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      add_row(pakc_pkg::OP_LOOKUP, k2, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      add_row(pakc_pkg::OP_LOOKUP, k1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);   // invalid identity
      add_row(pakc_pkg::OP_RECORD, kmax, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      add_row(pakc_pkg::OP_LOOKUP, kmax, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      add_row(pakc_pkg::OP_RECORD, kmin, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      add_row(pakc_pkg::OP_LOOKUP, kmin, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      kx = k1;
      kx.fork_num = 2'd3;
      add_row(pakc_pkg::OP_LOOKUP, kx, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      add_row(OP_UNUSED, k1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      add_row(pakc_pkg::OP_LOOKUP, k1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      add_row(pakc_pkg::OP_CLEAR, kmax, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      add_row(pakc_pkg::OP_LOOKUP, k1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);   // cleared entries miss
      add_row(pakc_pkg::OP_RECORD, k1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
      add_row(pakc_pkg::OP_LOOKUP, k1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_item(plan[i].req, plan[i].typed, plan[i].reply);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 300 == 0) steady = ($urandom_range(0, 3) == 0);
         send_item(random_request(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_replies.size() == 0) begin
         $display("page_anchor_key_cache_core test passed");
      end else begin
         $display("page_anchor_key_cache_core test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pakc_pkg.sv
rtl/pakc_key_ram.sv
rtl/pakc_key_cmp.sv
rtl/page_anchor_key_cache_core.sv
bench/page_anchor_key_cache_core_test.sv
